>>> hw/rtl/scp_pkg.sv
// Package for the sprite camera projection block.
// Holds status and register index codes and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package scp_pkg;

	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 768;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BEHIND   = 2'd1,
		ST_SINGULAR = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PLAYER_POS_X   = 3'd0,
		REG_PLAYER_POS_Y   = 3'd1,
		REG_VIEW_DIR_X     = 3'd2,
		REG_VIEW_DIR_Y     = 3'd3,
		REG_CAMERA_PLANE_X = 3'd4,
		REG_CAMERA_PLANE_Y = 3'd5
	} cfg_reg_t;

endpackage

>>> hw/rtl/scp_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Flags quotients of 2^QW or more as overflow. Standalone, no package use.
`timescale 1ns / 1ps

module scp_udiv #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay_in,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic [PW-1:0] pay_out
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic          v_s   [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] lo_s  [0:QW];
	logic [QW-1:0] q_s   [0:QW];
	logic [DW-1:0] den_s [0:QW];
	logic          ovf_s [0:QW];
	logic [PW-1:0] pay_s [0:QW];

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;

	assign hi_ext  = CW'(num[NW-1:QW]);
	assign den_ext = CW'(den);

	// Entry stage: quotient fits in QW bits exactly when the high part is below den.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= (hi_ext >= den_ext);
			rem_s[0] <= (hi_ext >= den_ext) ? '0 : DW'(num[NW-1:QW]);
			lo_s[0]  <= num[QW-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den;
			pay_s[0] <= pay_in;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k-1], lo_s[k-1][QW-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_s[k-1]}) : trial[DW-1:0];
				lo_s[k]  <= {lo_s[k-1][QW-2:0], 1'b0};
				q_s[k]   <= {q_s[k-1][QW-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				pay_s[k] <= pay_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign pay_out   = pay_s[QW];

endmodule

>>> hw/rtl/sprite_camera_projection.sv
// Sprite camera projection, top level: camera transform, two divider pipelines, clipping.
// Depends on scp_pkg and scp_udiv.
`timescale 1ns / 1ps
//
// Channel | Dir | Beat contents (lowest bit first)
// --------+-----+---------------------------------------------------------------
// s_axis  | in  | tdata: sprite_pos_x[31:0], sprite_pos_y[63:32]
// m_axis  | out | tuser: status; tdata: screen_column, sprite_size, row_start,
//         |     |        row_end, col_start, col_end, depth, zero pad to 120 bits
// cfg     | in  | cfg_we, cfg_index (register number), cfg_data (32 bits)
//
// One beat enters per cycle and one result leaves per cycle when the sink keeps
// up. The pipeline holds three transform stages, a 33-stage divider for the
// camera transform (one quotient bit per stage), two stages of clamping and
// setup, a 17-stage divider for column and size, a clamp stage and the output
// register. The whole pipeline advances as one when the output register is
// empty or being taken, so a stall holds every stage. Reset clears the valid
// bits and loads the default camera.

module sprite_camera_projection #(
	parameter int SCREEN_WIDTH  = scp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = scp_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [scp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,   // sprite_pos_x, sprite_pos_y
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [119:0]                   m_tdata,   // screen_column, sprite_size,
	                                                  // row_start, row_end, col_start,
	                                                  // col_end, depth, pad
	output logic [1:0]                     m_tuser    // status
);

	import scp_pkg::*;

	localparam int HALF_W   = SCREEN_WIDTH / 2;
	localparam int HALF_W_W = $clog2(HALF_W + 1);
	localparam int NC_W     = 33 + HALF_W_W;
	localparam int NS_W     = $clog2(SCREEN_HEIGHT + 1) + 16;

	localparam logic signed [17:0] HALF_H_X  = 18'(SCREEN_HEIGHT / 2);
	localparam logic signed [17:0] H_LAST_X  = 18'(SCREEN_HEIGHT - 1);
	localparam logic signed [17:0] W_LAST_X  = 18'(SCREEN_WIDTH - 1);
	localparam logic [NS_W-1:0]    SIZE_NUM  = NS_W'(SCREEN_HEIGHT) << 16;

	// Saturate a magnitude with sign to 32 bit signed.
	function automatic logic signed [31:0] sat32(input logic [31:0] mag, input logic ov,
		input logic neg);
		logic signed [31:0] r;
		if (neg) begin
			r = (ov || mag > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-mag);
		end else begin
			r = (ov || mag[31]) ? 32'sh7fff_ffff : $signed(mag);
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic [15:0] mag, input logic ov,
		input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			r = (ov || mag > 16'h8000) ? 16'sh8000 : $signed(-mag);
		end else begin
			r = (ov || mag[15]) ? 16'sh7fff : $signed(mag);
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [31:0] player_pos_x_q, player_pos_y_q;
	logic signed [15:0] view_dir_x_q, view_dir_y_q, camera_plane_x_q, camera_plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_pos_x_q   <= '0;
			player_pos_y_q   <= '0;
			view_dir_x_q     <= 16'sd16384;
			view_dir_y_q     <= '0;
			camera_plane_x_q <= '0;
			camera_plane_y_q <= 16'sd10813;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLAYER_POS_X:   player_pos_x_q   <= cfg_data;
				REG_PLAYER_POS_Y:   player_pos_y_q   <= cfg_data;
				REG_VIEW_DIR_X:     view_dir_x_q     <= cfg_data[15:0];
				REG_VIEW_DIR_Y:     view_dir_y_q     <= cfg_data[15:0];
				REG_CAMERA_PLANE_X: camera_plane_x_q <= cfg_data[15:0];
				REG_CAMERA_PLANE_Y: camera_plane_y_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Global advance: the pipeline moves when the output register can take a beat.
	logic en;
	logic out_v_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// Stage 1: offsets from the player, determinant of [plane dir].
	logic               v_s1;
	logic signed [32:0] dx_s1, dy_s1, det_s1;
	logic signed [31:0] sx, sy;
	logic signed [32:0] det_a, det_b;

	assign sx    = $signed(s_tdata[31:0]);
	assign sy    = $signed(s_tdata[63:32]);
	assign det_a = camera_plane_x_q * view_dir_y_q;
	assign det_b = view_dir_x_q * camera_plane_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= {sx[31], sx} - {player_pos_x_q[31], player_pos_x_q};
			dy_s1  <= {sy[31], sy} - {player_pos_y_q[31], player_pos_y_q};
			det_s1 <= det_a - det_b;
		end
	end

	// Stage 2: the four camera products.
	logic               v_s2;
	logic signed [48:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [32:0] det_s2;
	logic signed [48:0] p1, p2, p3, p4;

	assign p1 = view_dir_y_q * dx_s1;
	assign p2 = view_dir_x_q * dy_s1;
	assign p3 = camera_plane_x_q * dy_s1;
	assign p4 = camera_plane_y_q * dx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s2  <= p1;
			p2_s2  <= p2;
			p3_s2  <= p3;
			p4_s2  <= p4;
			det_s2 <= det_s1;
		end
	end

	// Stage 3: numerators to sign and magnitude, divisor magnitude.
	logic               v_s3;
	logic [63:0]        numx_s3, numy_s3;
	logic [31:0]        den_s3;
	logic               negx_s3, negy_s3, sing_s3;
	logic signed [49:0] nx, ny;
	logic [49:0]        mx, my;
	logic [32:0]        mdet;
	logic               sing;

	assign nx   = {p1_s2[48], p1_s2} - {p2_s2[48], p2_s2};
	assign ny   = {p3_s2[48], p3_s2} - {p4_s2[48], p4_s2};
	assign mx   = nx[49] ? 50'(-nx) : 50'(nx);
	assign my   = ny[49] ? 50'(-ny) : 50'(ny);
	assign mdet = det_s2[32] ? 33'(-det_s2) : 33'(det_s2);
	assign sing = (det_s2 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3 <= {mx, 14'b0};
			numy_s3 <= {my, 14'b0};
			// Feed a harmless divisor for a singular camera; the result is dropped.
			den_s3  <= sing ? 32'd1 : mdet[31:0];
			negx_s3 <= nx[49] ^ det_s2[32];
			negy_s3 <= ny[49] ^ det_s2[32];
			sing_s3 <= sing;
		end
	end

	// Camera transform division: tx and ty in lockstep.
	logic        dvx_v, dvy_v;
	logic [31:0] qx, qy;
	logic        ovx, ovy;
	logic [1:0]  payx;
	logic [0:0]  payy;

	scp_udiv #(.NW(64), .DW(32), .QW(32), .PW(2)) u_div_tx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(numx_s3), .den(den_s3), .pay_in({negx_s3, sing_s3}),
		.out_valid(dvx_v), .quo(qx), .ovf(ovx), .pay_out(payx)
	);

	scp_udiv #(.NW(64), .DW(32), .QW(32), .PW(1)) u_div_ty (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s3),
		.num(numy_s3), .den(den_s3), .pay_in(negy_s3),
		.out_valid(dvy_v), .quo(qy), .ovf(ovy), .pay_out(payy)
	);

	// Stage 4: saturate tx and ty.
	logic               v_s4;
	logic signed [31:0] tx_s4, ty_s4;
	logic               sing_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= dvx_v & dvy_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4   <= sat32(qx, ovx, payx[1]);
			ty_s4   <= sat32(qy, ovy, payy[0]);
			sing_s4 <= payx[0];
		end
	end

	// Stage 5: status and the column numerator.
	logic               v_s5;
	logic [NC_W-1:0]    numc_s5;
	logic [31:0]        den2_s5;
	logic               negc_s5;
	logic signed [31:0] ty_s5;
	status_t            st_s5;
	logic signed [32:0] csum;
	logic [32:0]        msum;
	logic               ty_pos;

	assign csum   = {ty_s4[31], ty_s4} + {tx_s4[31], tx_s4};
	assign msum   = csum[32] ? 33'(-csum) : 33'(csum);
	assign ty_pos = !ty_s4[31] && (ty_s4 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numc_s5 <= NC_W'(msum) * NC_W'(HALF_W);
			den2_s5 <= ty_pos ? ty_s4 : 32'd1;
			negc_s5 <= csum[32];
			ty_s5   <= sing_s4 ? 32'sd0 : ty_s4;
			if (sing_s4) begin
				st_s5 <= ST_SINGULAR;
			end else if (!ty_pos) begin
				st_s5 <= ST_BEHIND;
			end else begin
				st_s5 <= ST_OK;
			end
		end
	end

	// Screen column and size division.
	logic        dvc_v, dvs_v;
	logic [15:0] qc, qs;
	logic        ovc, ovs;
	logic [32:0] payc;
	logic [1:0]  pays;

	scp_udiv #(.NW(NC_W), .DW(32), .QW(16), .PW(33)) u_div_col (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(numc_s5), .den(den2_s5), .pay_in({negc_s5, ty_s5}),
		.out_valid(dvc_v), .quo(qc), .ovf(ovc), .pay_out(payc)
	);

	scp_udiv #(.NW(NS_W), .DW(32), .QW(16), .PW(2)) u_div_size (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.num(SIZE_NUM), .den(den2_s5), .pay_in(st_s5),
		.out_valid(dvs_v), .quo(qs), .ovf(ovs), .pay_out(pays)
	);

	// Stage 6: saturate column and size.
	logic               v_s6;
	logic signed [15:0] col_s6;
	logic [14:0]        size_s6;
	logic signed [31:0] ty_s6;
	status_t            st_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dvc_v & dvs_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s6  <= sat16(qc, ovc, payc[32]);
			size_s6 <= (ovs || qs[15]) ? 15'h7fff : qs[14:0];
			ty_s6   <= payc[31:0];
			st_s6   <= status_t'(pays);
		end
	end

	// Stage 7: clip extents, zero fields by status, output register.
	logic signed [17:0] half, col_x, rs, re, cs, ce;
	logic signed [17:0] rs_c, re_c, cs_c, ce_c;
	logic [112:0]       beat;

	assign half = 18'(size_s6[14:1]);
	assign col_x = 18'(col_s6);
	assign rs   = HALF_H_X - half;
	assign re   = HALF_H_X + half;
	assign cs   = col_x - half;
	assign ce   = col_x + half;
	assign rs_c = rs[17] ? 18'sd0 : rs;
	assign re_c = (re > H_LAST_X) ? H_LAST_X : re;
	assign cs_c = cs[17] ? 18'sd0 : cs;
	assign ce_c = (ce > W_LAST_X) ? W_LAST_X : ce;

	always_comb begin
		beat = '0;
		case (st_s6)
			ST_OK: begin
				beat = {ty_s6, ce_c[15:0], cs_c[14:0], re_c[9:0], rs_c[8:0], size_s6, col_s6};
			end
			ST_BEHIND: begin
				beat[112:81] = ty_s6;
			end
			default: beat = '0;
		endcase
	end

	logic [112:0] beat_q;
	logic [1:0]   st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= beat;
			st_q   <= st_s6;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'b0, beat_q};
	assign m_tuser  = st_q;

	// A singular camera leaves every field at zero.
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_SINGULAR) |-> (m_tdata == '0))
		else $error("singular result carries nonzero fields");

	// A projected sprite always has positive depth.
	a_ok_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_OK) |-> (!m_tdata[112] && m_tdata[112:81] != '0))
		else $error("projected sprite with nonpositive depth");

	// The two divider pipelines stay in lockstep.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(dvx_v == dvy_v) && (dvc_v == dvs_v))
		else $error("divider valid bits out of step");

endmodule

>>> test/sprite_camera_projection_checker.sv
// Result checker for the sprite camera projection testbench: tracks register writes,
// predicts each projection from accepted sprite beats and compares result beats.
// Depends on scp_pkg.
`timescale 1ns / 1ps

module sprite_camera_projection_checker #(
	parameter int SCREEN_WIDTH  = scp_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = scp_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [scp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [scp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [63:0]                     s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [119:0]                    m_tdata,
	input  logic [1:0]                      m_tuser,
	output int                              errors,
	output int                              pending
);

	import scp_pkg::*;

	// Highest bits first, so the layout matches {tuser, tdata} of a result beat.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] depth;
		logic [15:0] col_end;
		logic [14:0] col_start;
		logic [9:0]  row_end;
		logic [8:0]  row_start;
		logic [14:0] size;
		logic [15:0] column;
	} projection_t;

	longint cam_pos_x, cam_pos_y, dir_x, dir_y, plane_x, plane_y;
	projection_t projections[$];

	function automatic longint sat(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic projection_t project_sprite(logic [63:0] beat);
		projection_t r;
		longint dx, dy, det, tx, ty, col, size, half, rs, re, cs, ce;
		r = '0;
		dx = longint'($signed(beat[31:0])) - cam_pos_x;
		dy = longint'($signed(beat[63:32])) - cam_pos_y;
		det = plane_x * dir_y - dir_x * plane_y;
		if (det == 0) begin
			r.status = ST_SINGULAR;
			return r;
		end
		tx = sat(((dir_y * dx - dir_x * dy) * 16384) / det, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
		ty = sat(((plane_x * dy - plane_y * dx) * 16384) / det, -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		r.depth = ty[31:0];
		if (ty <= 0) begin
			r.status = ST_BEHIND;
			return r;
		end
		col = sat((longint'(SCREEN_WIDTH / 2) * (ty + tx)) / ty, -32768, 32767);
		size = sat((longint'(SCREEN_HEIGHT) * 65536) / ty, 0, 32767);
		half = size / 2;
		rs = sat(SCREEN_HEIGHT / 2 - half, 0, 64'sh7fffffff);
		re = sat(SCREEN_HEIGHT / 2 + half, 0, SCREEN_HEIGHT - 1);
		cs = (col - half < 0) ? 0 : col - half;
		ce = (col + half > SCREEN_WIDTH - 1) ? SCREEN_WIDTH - 1 : col + half;
		r.status    = ST_OK;
		r.column    = col[15:0];
		r.size      = size[14:0];
		r.row_start = rs[8:0];
		r.row_end   = re[9:0];
		r.col_start = cs[14:0];
		r.col_end   = ce[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
		errors++;
	endtask

	initial errors = 0;
	assign pending = projections.size();

	always @(posedge clk or negedge arst_n) begin
		projection_t want, got;
		if (!arst_n) begin
			cam_pos_x = 0;
			cam_pos_y = 0;
			dir_x = 16384;
			dir_y = 0;
			plane_x = 0;
			plane_y = 10813;
			projections.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PLAYER_POS_X:   cam_pos_x = longint'($signed(cfg_data));
					REG_PLAYER_POS_Y:   cam_pos_y = longint'($signed(cfg_data));
					REG_VIEW_DIR_X:     dir_x = longint'($signed(cfg_data[15:0]));
					REG_VIEW_DIR_Y:     dir_y = longint'($signed(cfg_data[15:0]));
					REG_CAMERA_PLANE_X: plane_x = longint'($signed(cfg_data[15:0]));
					REG_CAMERA_PLANE_Y: plane_y = longint'($signed(cfg_data[15:0]));
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				projections.push_back(project_sprite(s_tdata));
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[112:0]};
				if (projections.size() == 0) begin
					report_mismatch("unexpected beat", 0, got.status);
				end else begin
					want = projections.pop_front();
					if (want.status != got.status)
						report_mismatch("status", want.status, got.status);
					if (want.column != got.column)
						report_mismatch("screen_column", want.column, got.column);
					if (want.size != got.size)
						report_mismatch("sprite_size", want.size, got.size);
					if (want.row_start != got.row_start)
						report_mismatch("row_start", want.row_start, got.row_start);
					if (want.row_end != got.row_end)
						report_mismatch("row_end", want.row_end, got.row_end);
					if (want.col_start != got.col_start)
						report_mismatch("col_start", want.col_start, got.col_start);
					if (want.col_end != got.col_end)
						report_mismatch("col_end", want.col_end, got.col_end);
					if (want.depth != got.depth)
						report_mismatch("depth", want.depth, got.depth);
				end
			end
		end
	end

endmodule

>>> test/sprite_camera_projection_test.sv
// Top of the sprite camera projection testbench: clock, reset, camera settings,
// sprite stimulus with random idling and the verdict.
// Depends on scp_pkg, sprite_camera_projection and sprite_camera_projection_checker.
`timescale 1ns / 1ps

module sprite_camera_projection_test;
	import scp_pkg::*;

	// Pipeline depth of the block, plus margin for the final drain.
	localparam int PIPE_DEPTH  = 57;
	localparam int SETTLE      = PIPE_DEPTH + 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [63:0]            s_tdata = '0;   // sprite_pos_x, sprite_pos_y
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [119:0]           m_tdata;        // screen_column, sprite_size, row_start, row_end,
	                                        // col_start, col_end, depth, pad
	logic [1:0]             m_tuser;        // status
	int                     errors, pending;

	// Percent of cycles each side idles; changed per phase by the stimulus.
	int sender_idle = 30;
	int sink_idle   = 57;
	// Hold-off handshake between stimulus and sink process.
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int cycles        = 0;

	sprite_camera_projection u_dut (.*);

	sprite_camera_projection_checker u_checker (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Sink side: random stalls, or one long hold-off when asked so the pipeline fills
	// and backs up into the input.
	always @(posedge clk) begin
		if (hold_left == 0 && hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= sink_idle);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one sprite beat and hold it until the block takes it.
	task automatic send_sprite(logic [31:0] x, logic [31:0] y);
		while ($urandom_range(99) < sender_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every outstanding projection, then let the pipe settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Load the whole camera; the write enable stays high across the six beats.
	task automatic set_camera(logic [31:0] px, logic [31:0] py, logic [15:0] dx,
		logic [15:0] dy, logic [15:0] plx, logic [15:0] ply);
		logic [31:0] values [6];
		values = '{px, py, {16'd0, dx}, {16'd0, dy}, {16'd0, plx}, {16'd0, ply}};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data <= values[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] near_offset(logic [31:0] base, int span);
		return base + 32'($signed($urandom_range(0, 2 * span)) - span);
	endfunction

	// Mostly sprites around the player, plus full-range noise, extremes and the
	// player's own position (depth zero).
	task automatic send_random(logic [31:0] px, logic [31:0] py);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: send_sprite(near_offset(px, 1 << 21), near_offset(py, 1 << 21));
			5: send_sprite(near_offset(px, 1 << 12), near_offset(py, 1 << 12));
			6: send_sprite(near_offset(px, 1 << 28), near_offset(py, 1 << 28));
			7: send_sprite($urandom, $urandom);
			8: send_sprite($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff,
				$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
			default: send_sprite(px, py);
		endcase
	endtask

	initial begin
		logic [31:0] px, py;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, default camera looking down +x with a 0.66 plane.
		send_sprite(32'h0002_0000, 32'h0000_0000);   // straight ahead
		send_sprite(32'h0000_0000, 32'h0000_0000);   // on the camera plane
		send_sprite(32'hfffe_0000, 32'h0000_0000);   // behind
		send_sprite(32'h0000_0001, 32'h0000_0000);   // tiny depth, size saturates
		send_sprite(32'h0000_4000, 32'h0000_0000);   // near, rows clip
		send_sprite(32'h7fff_ffff, 32'h0000_0000);   // far, size near zero
		send_sprite(32'h7fff_ffff, 32'h7fff_ffff);
		send_sprite(32'h7fff_ffff, 32'h8000_0000);
		send_sprite(32'h8000_0000, 32'h7fff_ffff);
		send_sprite(32'h8000_0000, 32'h8000_0000);
		send_sprite(32'h0001_0000, 32'h0001_0000);   // column clips at the right
		send_sprite(32'h0001_0000, 32'hffff_0000);   // column clips at the left
		send_sprite(32'h0000_0001, 32'h7fff_ffff);   // column saturates
		send_sprite(32'h0000_0001, 32'h8000_0000);
		send_sprite(32'h0005_0000, 32'h0002_8000);
		send_sprite(32'hffff_ffff, 32'hffff_ffff);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			// Idling: sender light and sink heavy, then swapped, then none.
			sender_idle = (phase < 3) ? 30 : ((phase < 6) ? 57 : 0);
			sink_idle   = (phase < 3) ? 57 : ((phase < 6) ? 30 : 0);
			px = $urandom;
			py = $urandom;
			case (phase)
				0: begin px = 32'h0000_0000; py = 32'h0000_0000; end
				1: set_camera(px, py, 16'd0, 16'd16384, -16'sd10813, 16'd0);
				2: begin
					// Singular camera at extreme positions.
					px = 32'h7fff_ffff; py = 32'h8000_0000;
					set_camera(px, py, 16'd0, 16'd0, 16'd0, 16'd0);
				end
				3: begin
					px = 32'h8000_0000; py = 32'h7fff_ffff;
					set_camera(px, py, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
				end
				4: set_camera(px, py, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
				5: begin
					// Parallel direction and plane also make the camera singular.
					set_camera(px, py, 16'd16384, 16'd16384, 16'd8192, 16'd8192);
				end
				default: set_camera(px, py, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			endcase
			if (phase == 8) begin
				// Long sink hold-off while beats keep coming.
				hold_requests = hold_requests + 1;
			end
			for (int n = 0; n < 72; n++)
				send_random(px, py);
			drain();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
